>>> rtl/mbr_pkg.sv
// Shared constants, types and command codes of the block move engine.
`default_nettype none

package mbr_pkg;

    localparam int MEM_DEPTH = 1024;
    localparam int FIELD_W   = 10;
    localparam int BYTE_W    = 8;
    localparam int CMD_W     = 2;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int CNT_W     = $clog2(MEM_DEPTH + 1);
    localparam int CMP_W     = ((FIELD_W > ADDR_W) ? FIELD_W : ADDR_W) + 1;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [CMP_W-1:0]   cmp_t;
    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [BYTE_W-1:0]  byte_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_MOVE  = 2'd2,
        CMD_ZERO  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t   cmd;
        field_t first_addr;
        field_t last_addr;
        field_t target_addr;
        byte_t  write_byte;
    } req_t;

    typedef struct packed {
        byte_t read_byte;
        logic  ok;
    } rsp_t;

    // Operands of the shared address step unit
    typedef struct packed {
        logic  wrap;
        addr_t cur;
        addr_t amt;
        addr_t hi;
        cnt_t  n;
    } adv_req_t;

    // Sequencer status toward the channel logic
    typedef struct packed {
        logic idle;
        logic res_valid;
    } core_stat_t;

endpackage

`default_nettype wire

>>> rtl/mbr_if.sv
// Request and response channel interfaces of the block move engine.
`default_nettype none

interface mbr_req_if;
    logic                        valid;
    logic                        ready;
    logic [mbr_pkg::CMD_W-1:0]   cmd;
    logic [mbr_pkg::FIELD_W-1:0] first_addr;
    logic [mbr_pkg::FIELD_W-1:0] last_addr;
    logic [mbr_pkg::FIELD_W-1:0] target_addr;
    logic [mbr_pkg::BYTE_W-1:0]  write_byte;

    modport source (output valid, cmd, first_addr, last_addr, target_addr, write_byte,
                    input ready);
    modport sink (input valid, cmd, first_addr, last_addr, target_addr, write_byte,
                  output ready);
endinterface

interface mbr_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [mbr_pkg::BYTE_W-1:0] read_byte;
    logic                       ok;

    modport source (output valid, read_byte, ok, input ready);
    modport sink (input valid, read_byte, ok, output ready);
endinterface

`default_nettype wire

>>> rtl/mbr_adv.sv
// Shared address step unit: increment, or advance by the shift amount modulo the region.
`default_nettype none

module mbr_adv (
    input  mbr_pkg::adv_req_t step,
    output mbr_pkg::addr_t    next_addr
);
    import mbr_pkg::*;

    localparam int SUM_W = ADDR_W + 1;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] wrapped;

    always_comb
    begin
        sum     = {1'b0, step.cur} + (step.wrap ? {1'b0, step.amt} : SUM_W'(1));
        wrapped = sum - SUM_W'(step.n);
        // stay inside the region: fold back past its last byte
        if (step.wrap && (sum > {1'b0, step.hi}))
        begin
            next_addr = wrapped[ADDR_W-1:0];
        end
        else
        begin
            next_addr = sum[ADDR_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> rtl/mbr_core.sv
// Command sequencer with the byte memory; moves follow the rotation cycles one byte at a time.
`default_nettype none

module mbr_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  mbr_pkg::req_t       req,
    input  logic                res_take,
    output mbr_pkg::core_stat_t stat,
    output mbr_pkg::rsp_t       res
);
    import mbr_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CHECK  = 9'b000000010,
        S_PLAN   = 9'b000000100,
        S_RDWAIT = 9'b000001000,
        S_ZERO   = 9'b000010000,
        S_TMP    = 9'b000100000,
        S_FOLLOW = 9'b001000000,
        S_MOVEWR = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    localparam cmp_t DEPTH_C = CMP_W'(MEM_DEPTH);

    state_t state_reg, state_next;
    req_t   req_reg, req_next;
    cmp_t   dend_reg, dend_next;
    cmp_t   span_reg, span_next;
    addr_t  start_reg, start_next;
    addr_t  cur_reg, cur_next;
    addr_t  nxt_reg, nxt_next;
    addr_t  hi_reg, hi_next;
    addr_t  amt_reg, amt_next;
    cnt_t   n_reg, n_next;
    cnt_t   cnt_reg, cnt_next;
    byte_t  tmp_reg, tmp_next;
    byte_t  rdata_reg;
    rsp_t   res_reg, res_next;

    byte_t  mem [MEM_DEPTH];
    logic   mem_we;
    addr_t  mem_waddr;
    byte_t  mem_wdata;
    logic   mem_re;
    addr_t  mem_raddr;

    adv_req_t step;
    addr_t    step_addr;

    cmp_t fw, lw, tw, span, dend;
    cmp_t lo_c, hi_c, amt_c, n_c;
    logic first_ok, rng_ok, mv_ok;
    addr_t start_inc;

    assign step.wrap = (state_reg != S_ZERO);
    assign step.cur  = cur_reg;
    assign step.amt  = amt_reg;
    assign step.hi   = hi_reg;
    assign step.n    = n_reg;

    mbr_adv u_adv (
        .step      (step),
        .next_addr (step_addr)
    );

    assign fw        = CMP_W'(req_reg.first_addr);
    assign lw        = CMP_W'(req_reg.last_addr);
    assign tw        = CMP_W'(req_reg.target_addr);
    assign span      = lw - fw;
    assign dend      = tw + span;
    assign first_ok  = (fw < DEPTH_C);
    assign rng_ok    = (fw <= lw) && (lw < DEPTH_C);
    assign mv_ok     = rng_ok && (tw != fw) && (dend < DEPTH_C);
    assign start_inc = start_reg + addr_t'(1);

    // Covering region and shift: upward moves rotate by the block length,
    // downward moves by the distance moved.
    always_comb
    begin
        if (fw < tw)
        begin
            lo_c  = fw;
            hi_c  = dend_reg;
            amt_c = span_reg + cmp_t'(1);
        end
        else
        begin
            lo_c  = tw;
            hi_c  = lw;
            amt_c = fw - tw;
        end
        n_c = hi_c - lo_c + cmp_t'(1);
    end

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        dend_next  = dend_reg;
        span_next  = span_reg;
        start_next = start_reg;
        cur_next   = cur_reg;
        nxt_next   = nxt_reg;
        hi_next    = hi_reg;
        amt_next   = amt_reg;
        n_next     = n_reg;
        cnt_next   = cnt_reg;
        tmp_next   = tmp_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = cur_reg;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = cur_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                res_next   = '0;
                dend_next  = dend;
                span_next  = span;
                state_next = S_DONE;
                case (req_reg.cmd)
                    CMD_WRITE:
                    begin
                        if (first_ok)
                        begin
                            mem_we      = 1'b1;
                            mem_waddr   = fw[ADDR_W-1:0];
                            mem_wdata   = req_reg.write_byte;
                            res_next.ok = 1'b1;
                        end
                    end
                    CMD_READ:
                    begin
                        if (first_ok)
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = fw[ADDR_W-1:0];
                            state_next = S_RDWAIT;
                        end
                    end
                    CMD_MOVE:
                    begin
                        if (mv_ok)
                        begin
                            state_next = S_PLAN;
                        end
                    end
                    CMD_ZERO:
                    begin
                        if (rng_ok)
                        begin
                            cur_next   = fw[ADDR_W-1:0];
                            hi_next    = lw[ADDR_W-1:0];
                            state_next = S_ZERO;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_RDWAIT:
            begin
                res_next.read_byte = rdata_reg;
                res_next.ok        = 1'b1;
                state_next         = S_DONE;
            end
            S_ZERO:
            begin
                mem_we    = 1'b1;
                mem_waddr = cur_reg;
                if (cur_reg == hi_reg)
                begin
                    res_next.ok = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cur_next = step_addr;
                end
            end
            S_PLAN:
            begin
                start_next = lo_c[ADDR_W-1:0];
                cur_next   = lo_c[ADDR_W-1:0];
                hi_next    = hi_c[ADDR_W-1:0];
                amt_next   = amt_c[ADDR_W-1:0];
                n_next     = n_c[CNT_W-1:0];
                cnt_next   = '0;
                mem_re     = 1'b1;
                mem_raddr  = lo_c[ADDR_W-1:0];
                state_next = S_TMP;
            end
            S_TMP:
            begin
                // hold the first byte of the cycle until the cycle closes
                tmp_next   = rdata_reg;
                state_next = S_FOLLOW;
            end
            S_FOLLOW:
            begin
                if (step_addr == start_reg)
                begin
                    // close the cycle with the held byte
                    mem_we    = 1'b1;
                    mem_waddr = cur_reg;
                    mem_wdata = tmp_reg;
                    cnt_next  = cnt_reg + cnt_t'(1);
                    if ((cnt_reg + cnt_t'(1)) == n_reg)
                    begin
                        res_next.ok = 1'b1;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        start_next = start_inc;
                        cur_next   = start_inc;
                        mem_re     = 1'b1;
                        mem_raddr  = start_inc;
                        state_next = S_TMP;
                    end
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = step_addr;
                    nxt_next   = step_addr;
                    state_next = S_MOVEWR;
                end
            end
            S_MOVEWR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = cur_reg;
                mem_wdata  = rdata_reg;
                cur_next   = nxt_reg;
                cnt_next   = cnt_reg + cnt_t'(1);
                state_next = S_FOLLOW;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        dend_reg  <= dend_next;
        span_reg  <= span_next;
        start_reg <= start_next;
        cur_reg   <= cur_next;
        nxt_reg   <= nxt_next;
        hi_reg    <= hi_next;
        amt_reg   <= amt_next;
        n_reg     <= n_next;
        cnt_reg   <= cnt_next;
        tmp_reg   <= tmp_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign stat.idle      = (state_reg == S_IDLE);
    assign stat.res_valid = (state_reg == S_DONE);
    assign res            = res_reg;

endmodule

`default_nettype wire

>>> rtl/memory_block_rotate_engine.sv
// Top level of the byte memory with in-place block move: channels, response register, checks.
//
// Takes one request at a time and answers each with exactly one response. A move
// rotates the covering region of n bytes (source and target together) by following its
// g = gcd(n, shift) cycles through the byte memory, which takes one read and one write
// port: each byte is read and then written, and the first byte of each cycle is read
// ahead while the previous cycle closes. A stalled response channel delays the
// responses. The memory holds no defined value until written; it needs no clearing
// after reset. A finished response waits in an output register while the next request
// is already being taken.
`default_nettype none

module memory_block_rotate_engine (
    input  logic       clk,
    input  logic       rst_n,
    mbr_req_if.sink    req,
    mbr_rsp_if.source  rsp
);
    import mbr_pkg::*;

    req_t       core_req;
    rsp_t       core_res;
    core_stat_t core_stat;
    logic       start;
    logic       res_take;

    logic out_valid_reg, out_valid_next;
    rsp_t out_reg, out_next;

    assign core_req.cmd         = cmd_t'(req.cmd);
    assign core_req.first_addr  = req.first_addr;
    assign core_req.last_addr   = req.last_addr;
    assign core_req.target_addr = req.target_addr;
    assign core_req.write_byte  = req.write_byte;

    assign req.ready = core_stat.idle;
    assign start     = req.valid && core_stat.idle;
    assign res_take  = !out_valid_reg || rsp.ready;

    mbr_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (core_req),
        .res_take (res_take),
        .stat     (core_stat),
        .res      (core_res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (core_stat.res_valid && res_take)
        begin
            out_valid_next = 1'b1;
            out_next       = core_res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_byte = out_reg.read_byte;
    assign rsp.ok        = out_reg.ok;

`ifndef NO_ASSERTIONS
    a_core_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (core_stat.res_valid && !res_take) |=> (core_stat.res_valid && $stable(core_res)))
        else $error("core response changed or dropped while blocked");

    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |-> !core_stat.res_valid)
        else $error("request accepted while a core response is pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("engine still ready after taking a request");

    a_reject_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ok) |-> (rsp.read_byte == '0))
        else $error("rejected request returned a nonzero byte");
`endif

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench of the block move engine: byte memory model, scoreboard, random stalls.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mbr_pkg::*;

    logic clk;
    logic rst_n;

    mbr_req_if req_ch ();
    mbr_rsp_if rsp_ch ();

    memory_block_rotate_engine DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Model of the memory contents and of which bytes hold a defined value
    byte_t byte_image [MEM_DEPTH];
    bit    byte_written [MEM_DEPTH];

    rsp_t expected_responses [$];
    bit   idle_enabled = 1'b1;
    int   fail_count     = 0;
    int   checked_count  = 0;
    int   rejected_count = 0;
    int   sent_by_cmd [4];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Rotate [lo, hi] so that the byte at lo + k becomes the old byte at lo + (k + amt) mod n.
    function automatic void rotate_span(input int lo, input int hi, input int amt);
        byte_t tmp_byte [MEM_DEPTH];
        bit    tmp_mark [MEM_DEPTH];
        int    n;
        int    k;
        n = hi - lo + 1;
        for (k = 0; k < n; k++)
        begin
            tmp_byte[k] = byte_image[lo + (k + amt) % n];
            tmp_mark[k] = byte_written[lo + (k + amt) % n];
        end
        for (k = 0; k < n; k++)
        begin
            byte_image[lo + k]   = tmp_byte[k];
            byte_written[lo + k] = tmp_mark[k];
        end
    endfunction

    // Apply one request to the memory image and return the response it must produce.
    function automatic rsp_t step_memory_model(input req_t r);
        rsp_t res;
        int   s;
        int   e;
        int   d;
        int   len;
        int   i;
        res = '0;
        s   = int'(r.first_addr);
        e   = int'(r.last_addr);
        d   = int'(r.target_addr);
        case (r.cmd)
            CMD_WRITE:
            begin
                if (s < MEM_DEPTH)
                begin
                    byte_image[s]   = r.write_byte;
                    byte_written[s] = 1'b1;
                    res.ok = 1'b1;
                end
            end
            CMD_READ:
            begin
                if (s < MEM_DEPTH)
                begin
                    res.read_byte = byte_image[s];
                    res.ok = 1'b1;
                end
            end
            CMD_MOVE:
            begin
                if (s <= e && e < MEM_DEPTH && d != s)
                begin
                    len = e - s + 1;
                    if (d + len - 1 < MEM_DEPTH)
                    begin
                        res.ok = 1'b1;
                        if (s < d)
                            rotate_span(s, d + len - 1, len);
                        else
                            rotate_span(d, e, s - d);
                    end
                end
            end
            default:
            begin
                if (s <= e && e < MEM_DEPTH)
                begin
                    for (i = s; i <= e; i++)
                    begin
                        byte_image[i]   = '0;
                        byte_written[i] = 1'b1;
                    end
                    res.ok = 1'b1;
                end
            end
        endcase
        return res;
    endfunction

    function automatic bit pick_written_addr(input int start, output int addr);
        int i;
        int a;
        for (i = 0; i < MEM_DEPTH; i++)
        begin
            a = (start + i) % MEM_DEPTH;
            if (byte_written[a])
            begin
                addr = a;
                return 1'b1;
            end
        end
        addr = start;
        return 1'b0;
    endfunction

    function automatic req_t make_random_request();
        req_t r;
        int   roll;
        int   lim;
        int   len;
        int   s;
        int   d;
        int   a;
        r.cmd         = cmd_t'($urandom_range(3));
        r.first_addr  = field_t'($urandom);
        r.last_addr   = field_t'($urandom);
        r.target_addr = field_t'($urandom);
        r.write_byte  = byte_t'($urandom);
        roll = $urandom_range(99);
        // Half the traffic stays in a small window so moves and reads hit written data
        lim = ($urandom_range(1) == 0) ? 64 : MEM_DEPTH;
        if (roll < 5)
        begin
            // noise: leave the fields as drawn
        end
        else if (roll < 40)
        begin
            r.cmd = CMD_WRITE;
            r.first_addr = field_t'($urandom_range(lim - 1));
        end
        else if (roll < 65)
        begin
            r.cmd = CMD_READ;
            r.first_addr = field_t'($urandom_range(lim - 1));
        end
        else if (roll < 90)
        begin
            r.cmd = CMD_MOVE;
            len = ($urandom_range(29) == 0) ? $urandom_range(MEM_DEPTH - 1, 1)
                                            : $urandom_range(16, 1);
            if (len >= lim)
                lim = MEM_DEPTH;
            s = $urandom_range(lim - len);
            d = $urandom_range(lim - len);
            if (d == s)
                d = (s == 0) ? 1 : s - 1;
            r.first_addr  = field_t'(s);
            r.last_addr   = field_t'(s + len - 1);
            r.target_addr = field_t'(d);
            if ($urandom_range(9) == 0)
            begin
                case ($urandom_range(2))
                    0: r.target_addr = r.first_addr;
                    1:
                    begin
                        if (s == 0)
                            r.first_addr = field_t'(1);
                        r.last_addr = r.first_addr - 1'b1;
                    end
                    default: r.target_addr = field_t'(MEM_DEPTH - 1);
                endcase
            end
        end
        else
        begin
            r.cmd = CMD_ZERO;
            len = $urandom_range(32, 1);
            s = $urandom_range(((lim > len) ? lim : MEM_DEPTH) - len);
            r.first_addr = field_t'(s);
            r.last_addr  = field_t'(s + len - 1);
            if ($urandom_range(9) == 0)
            begin
                r.first_addr = field_t'(s + len);
                r.last_addr  = field_t'(s);
            end
        end
        // Never read a byte that holds no defined value
        if (r.cmd == CMD_READ)
        begin
            if (pick_written_addr(int'(r.first_addr), a))
                r.first_addr = field_t'(a);
            else
                r.cmd = CMD_WRITE;
        end
        return r;
    endfunction

    task automatic send_request(input req_t r);
        rsp_t want;
        @(negedge clk);
        while (idle_enabled && $urandom_range(99) < 24)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid       = 1'b1;
        req_ch.cmd         = r.cmd;
        req_ch.first_addr  = r.first_addr;
        req_ch.last_addr   = r.last_addr;
        req_ch.target_addr = r.target_addr;
        req_ch.write_byte  = r.write_byte;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        want = step_memory_model(r);
        expected_responses.push_back(want);
        sent_by_cmd[r.cmd]++;
    endtask

    task automatic issue(input cmd_t c, input int first, input int last, input int target,
                         input int wbyte);
        req_t r;
        r.cmd         = c;
        r.first_addr  = field_t'(first);
        r.last_addr   = field_t'(last);
        r.target_addr = field_t'(target);
        r.write_byte  = byte_t'(wbyte);
        send_request(r);
    endtask

    // Drop valid and hold until every pending response has come back.
    task automatic wait_for_responses();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (expected_responses.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed_cases();
        issue(CMD_WRITE, 0, 1023, 1023, 8'hFF);
        issue(CMD_WRITE, 1023, 0, 0, 8'h00);
        issue(CMD_WRITE, 512, 5, 9, 8'hA5);
        issue(CMD_READ, 0, 1023, 1023, 8'hFF);
        issue(CMD_READ, 1023, 0, 0, 8'h00);
        issue(CMD_READ, 512, 0, 0, 8'h5A);
        issue(CMD_ZERO, 1000, 1023, 0, 8'hFF);
        issue(CMD_READ, 1010, 0, 0, 0);
        // empty range, empty source, target equal to source, target past the end
        issue(CMD_ZERO, 5, 4, 0, 0);
        issue(CMD_MOVE, 7, 3, 100, 0);
        issue(CMD_MOVE, 0, 9, 0, 0);
        issue(CMD_MOVE, 0, 9, 1020, 0);
        issue(CMD_WRITE, 20, 0, 0, 8'h11);
        issue(CMD_WRITE, 21, 0, 0, 8'h22);
        issue(CMD_WRITE, 22, 0, 0, 8'h33);
        issue(CMD_WRITE, 23, 0, 0, 8'h44);
        // moves upward and downward, to adjacent and to distant targets
        issue(CMD_MOVE, 20, 21, 22, 0);
        issue(CMD_READ, 22, 0, 0, 0);
        issue(CMD_MOVE, 22, 23, 20, 0);
        issue(CMD_READ, 21, 0, 0, 0);
        issue(CMD_MOVE, 1000, 1009, 1014, 0);
        issue(CMD_READ, 1023, 0, 0, 0);
        issue(CMD_MOVE, 512, 512, 0, 0);
        issue(CMD_READ, 0, 0, 0, 0);
    endtask

    task automatic test_random_mix(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_request(make_random_request());
    endtask

    task automatic test_back_to_back(input int count);
        idle_enabled = 1'b0;
        test_random_mix(count);
        wait_for_responses();
        idle_enabled = 1'b1;
    endtask

    task automatic test_full_span();
        issue(CMD_ZERO, 0, 1023, 0, 0);
        issue(CMD_WRITE, 1022, 0, 0, 8'hC3);
        issue(CMD_MOVE, 0, 1022, 1, 0);
        issue(CMD_READ, 1023, 0, 0, 0);
        issue(CMD_MOVE, 1, 1023, 0, 0);
        issue(CMD_READ, 1022, 0, 0, 0);
        test_random_mix(10);
    endtask

    // Response checker: random backpressure, compare with the oldest expectation
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready = !idle_enabled || ($urandom_range(99) >= 24);
        end
    end

    always @(posedge clk)
    begin : check_response
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_responses.size() == 0)
            begin
                $error("response with no request pending: read_byte %0d ok %0d",
                       rsp_ch.read_byte, rsp_ch.ok);
                fail_count++;
            end
            else
            begin
                want = expected_responses.pop_front();
                checked_count++;
                if (!want.ok)
                    rejected_count++;
                if (rsp_ch.read_byte !== want.read_byte)
                begin
                    $error("read_byte: expected %0d, actual %0d", want.read_byte,
                           rsp_ch.read_byte);
                    fail_count++;
                end
                if (rsp_ch.ok !== want.ok)
                begin
                    $error("ok: expected %0d, actual %0d", want.ok, rsp_ch.ok);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.cmd         = '0;
        req_ch.first_addr  = '0;
        req_ch.last_addr   = '0;
        req_ch.target_addr = '0;
        req_ch.write_byte  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_random_mix(120);
        // hold off new requests until the engine has answered everything
        wait_for_responses();
        test_back_to_back(60);
        test_random_mix(70);
        test_full_span();

        wait_for_responses();
        repeat (64) @(posedge clk);
        $display("Sent %0d writes, %0d reads, %0d moves and %0d zero-range requests",
                 sent_by_cmd[CMD_WRITE], sent_by_cmd[CMD_READ], sent_by_cmd[CMD_MOVE],
                 sent_by_cmd[CMD_ZERO]);
        $display("Checked %0d responses, %0d of them rejections", checked_count,
                 rejected_count);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
